// ----- sv/assert_macros.svh -----
// Assertion helpers used by the checker file trcc_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked on clk, ignored while rst is high.
`define TRCC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked on clk, also checked through reset.
`define TRCC_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/trcc_pkg.sv -----
package trcc_pkg;

  // config register indexes
  localparam logic CFG_HEADER_MODE = 1'b0;
  localparam logic CFG_DATA_LENGTH = 1'b1;

  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_DATA_W-1:0] DATA_LENGTH_RESET = 13'd6272;

  // header check modes (3 behaves as unchecked)
  localparam logic [1:0] HM_ZERO = 2'd0;
  localparam logic [1:0] HM_SYNC = 2'd1;
  localparam logic [1:0] HM_NONE = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_HDR  = 2'd1;
  localparam logic [1:0] ST_LEN  = 2'd2;
  localparam logic [1:0] ST_CSUM = 2'd3;

  // result kinds
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [6:0] {
    PH_IDLE  = 7'b0000001,
    PH_CHK1  = 7'b0000010,
    PH_LEN1  = 7'b0000100,
    PH_LEN2  = 7'b0001000,
    PH_DATA  = 7'b0010000,
    PH_TRAIL = 7'b0100000,
    PH_CSUM  = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] word;
    logic [1:0]  status;
    logic [15:0] chk1;
    logic [15:0] len2;
    logic [15:0] sync;
  } res_t;

  // EOR then rotate right by one
  function automatic logic [15:0] sum_step(input logic [15:0] sum, input logic [15:0] w);
    logic [15:0] s;
    s = sum ^ w;
    return {s[0], s[15:1]};
  endfunction

endpackage

// ----- sv/trcc_seq.sv -----
module trcc_seq #(
  parameter int MAX_DATA_BYTES = 8190
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic                            cfg_index,
  input  logic [trcc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            take,
  input  logic                            start_req,
  input  logic [15:0]                     data_word,
  input  logic [15:0]                     sync_word,
  output logic                            res_push,
  output trcc_pkg::res_t                  res
);

  localparam int WL_W = $clog2(MAX_DATA_BYTES / 2 + 1);
  localparam logic [15:0] MAX_BYTES = 16'(MAX_DATA_BYTES);

  logic [1:0]                      header_mode;
  logic [trcc_pkg::CFG_DATA_W-1:0] data_length_bytes;

  trcc_pkg::phase_t phase, phase_next;
  logic [WL_W-1:0]  words_left, words_left_next;
  logic [15:0]      running_sum, running_sum_next;
  logic [15:0]      held_chk1, held_chk1_next;
  logic [15:0]      held_len2, held_len2_next;
  logic [15:0]      held_sync, held_sync_next;

  logic [15:0]     len16;
  logic [15:0]     eff_bytes;
  logic [WL_W-1:0] word_count;
  logic [WL_W-1:0] wl_dec;
  logic [15:0]     sum_w;
  logic            hdr_bad;

  assign len16      = {3'b000, data_length_bytes};
  assign eff_bytes  = (len16 > MAX_BYTES) ? MAX_BYTES : len16;
  assign word_count = WL_W'(eff_bytes >> 1);
  assign wl_dec     = words_left - WL_W'(1);
  assign sum_w      = trcc_pkg::sum_step(running_sum, data_word);
  assign hdr_bad    = ((header_mode == trcc_pkg::HM_ZERO) && (data_word != 16'h0000)) ||
                      ((header_mode == trcc_pkg::HM_SYNC) && (data_word != sync_word));

  always_comb begin
    phase_next       = phase;
    words_left_next  = words_left;
    running_sum_next = running_sum;
    held_chk1_next   = held_chk1;
    held_len2_next   = held_len2;
    held_sync_next   = held_sync;
    res_push         = 1'b0;
    res              = '0;
    res.kind         = trcc_pkg::KIND_STATUS;

    if (start_req) begin
      held_sync_next   = sync_word;
      held_chk1_next   = '0;
      held_len2_next   = '0;
      words_left_next  = '0;
      if (hdr_bad) begin
        running_sum_next = '0;
        phase_next       = trcc_pkg::PH_IDLE;
        res_push         = 1'b1;
        res.status       = trcc_pkg::ST_HDR;
      end else begin
        running_sum_next = trcc_pkg::sum_step(16'h0000, data_word);
        phase_next       = trcc_pkg::PH_CHK1;
      end
    end else begin
      unique case (phase)
        trcc_pkg::PH_IDLE: begin
        end
        trcc_pkg::PH_CHK1: begin
          held_chk1_next   = data_word;
          running_sum_next = sum_w;
          phase_next       = trcc_pkg::PH_LEN1;
        end
        trcc_pkg::PH_LEN1: begin
          if (data_word != len16) begin
            res_push        = 1'b1;
            res.status      = trcc_pkg::ST_LEN;
            phase_next      = trcc_pkg::PH_IDLE;
            words_left_next = '0;
          end else begin
            running_sum_next = sum_w;
            words_left_next  = word_count;
            phase_next       = trcc_pkg::PH_LEN2;
          end
        end
        trcc_pkg::PH_LEN2: begin
          held_len2_next   = data_word;
          running_sum_next = sum_w;
          phase_next       = (words_left == '0) ? trcc_pkg::PH_TRAIL : trcc_pkg::PH_DATA;
        end
        trcc_pkg::PH_DATA: begin
          running_sum_next = sum_w;
          res_push         = 1'b1;
          res.kind         = trcc_pkg::KIND_DATA;
          res.word         = data_word;
          if (words_left != '0) begin
            words_left_next = wl_dec;
            if (wl_dec == '0) phase_next = trcc_pkg::PH_TRAIL;
          end else begin
            phase_next = trcc_pkg::PH_TRAIL;
          end
        end
        trcc_pkg::PH_TRAIL: begin
          running_sum_next = sum_w;
          phase_next       = trcc_pkg::PH_CSUM;
        end
        trcc_pkg::PH_CSUM: begin
          res_push        = 1'b1;
          res.status      = (data_word == running_sum) ? trcc_pkg::ST_OK : trcc_pkg::ST_CSUM;
          phase_next      = trcc_pkg::PH_IDLE;
          words_left_next = '0;
        end
        default: begin
          phase_next = trcc_pkg::PH_IDLE;
        end
      endcase
    end

    // status items carry the capture as it stands after this word
    if (res.kind == trcc_pkg::KIND_STATUS) begin
      res.chk1 = held_chk1_next;
      res.len2 = held_len2_next;
      res.sync = held_sync_next;
    end
    if (!take) res_push = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_mode       <= trcc_pkg::HM_ZERO;
      data_length_bytes <= trcc_pkg::DATA_LENGTH_RESET;
    end else if (cfg_wr_en) begin
      if (cfg_index == trcc_pkg::CFG_HEADER_MODE) header_mode <= cfg_data[1:0];
      else                                        data_length_bytes <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= trcc_pkg::PH_IDLE;
      words_left  <= '0;
      running_sum <= '0;
      held_chk1   <= '0;
      held_len2   <= '0;
      held_sync   <= '0;
    end else if (take) begin
      phase       <= phase_next;
      words_left  <= words_left_next;
      running_sum <= running_sum_next;
      held_chk1   <= held_chk1_next;
      held_len2   <= held_len2_next;
      held_sync   <= held_sync_next;
    end
  end

endmodule

// ----- sv/trcc_outq.sv -----
module trcc_outq (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  trcc_pkg::res_t res_in,
  input  logic           pop_stall,
  output logic           res_valid,
  output trcc_pkg::res_t res_out,
  output logic           full
);

  // two entries: one on show, one to absorb a transaction while stalled
  trcc_pkg::res_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign res_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign pop       = res_valid && !pop_stall;
  assign res_out   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= res_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- sv/track_record_checksum_checker.sv -----
// Track record checksum checker.
// Input channel (in_valid / in_stall): one decoded 16-bit word per transaction.
//   start_req marks the header word of a record and comes with the matched sync.
// Output channel (out_valid / out_stall): zero or one result per input word,
//   either a passed-through data word (kind 0) or an end-of-record status
//   (kind 1) with the captured chk1, len2 and sync.
// Config port (cfg_wr_en / cfg_index / cfg_data): index 0 header_mode,
//   index 1 data_length_bytes; write only while no record is in flight.
// Throughput: one word per cycle while in_stall is low. The sequencer updates its
//   record state and forms the result in the cycle a word is taken; the result is
//   then registered in the output queue before it shows on out_valid.
// The output side is a two-entry queue, so a word is still taken in the cycle
//   the receiver stalls; in_stall rises only once both entries are held.
// Reset (rst, synchronous): record state idle, queue empty, header_mode 0,
//   data_length_bytes 6272.
module track_record_checksum_checker #(
  parameter int MAX_DATA_BYTES = 8190
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic                            cfg_index,
  input  logic [trcc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            start_req,
  input  logic [15:0]                     data_word,
  input  logic [15:0]                     sync_word,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            kind,
  output logic [15:0]                     out_word,
  output logic [1:0]                      status,
  output logic [15:0]                     chk1_value,
  output logic [15:0]                     len2_value,
  output logic [15:0]                     sync_value
);

  logic           take;
  logic           res_push;
  logic           q_full;
  trcc_pkg::res_t res;
  trcc_pkg::res_t res_out;

  // stall only when the queue cannot absorb a result
  assign in_stall = q_full;
  assign take     = in_valid && !q_full;

  trcc_seq #(
    .MAX_DATA_BYTES(MAX_DATA_BYTES)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .start_req (start_req),
    .data_word (data_word),
    .sync_word (sync_word),
    .res_push  (res_push),
    .res       (res)
  );

  trcc_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .res_in    (res),
    .pop_stall (out_stall),
    .res_valid (out_valid),
    .res_out   (res_out),
    .full      (q_full)
  );

  assign kind       = res_out.kind;
  assign out_word   = res_out.word;
  assign status     = res_out.status;
  assign chk1_value = res_out.chk1;
  assign len2_value = res_out.len2;
  assign sync_value = res_out.sync;

endmodule

// ----- sv/trcc_checker.sv -----
`include "assert_macros.svh"

module trcc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        kind,
  input logic [15:0] out_word,
  input logic [1:0]  status,
  input logic [15:0] chk1_value,
  input logic [15:0] len2_value
);

  `TRCC_ASSERT_RST(a_reset_empty, rst |=> !out_valid, "output valid right after reset")

  `TRCC_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_word), "stalled output transaction dropped or changed")

  `TRCC_ASSERT(a_data_clean, out_valid && (kind == trcc_pkg::KIND_DATA) |-> (status == trcc_pkg::ST_OK) && (chk1_value == 16'h0000) && (len2_value == 16'h0000), "data item carries status fields")

  `TRCC_ASSERT(a_hdr_fail_empty, out_valid && (kind == trcc_pkg::KIND_STATUS) && (status == trcc_pkg::ST_HDR) |-> (chk1_value == 16'h0000) && (len2_value == 16'h0000) && (out_word == 16'h0000), "header failure reports stale capture")

  `TRCC_ASSERT(a_stall_only_full, in_valid && in_stall |-> $past(out_valid) && out_valid, "input stalled with empty output side")

endmodule

bind track_record_checksum_checker trcc_checker u_trcc_checker (.*);
